>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/chl_pkg.sv
// shared types, character codes and keyword tables for the coding history parser
// no dependencies
`default_nettype none

package chl_pkg;

  localparam int ALG_CHARS = 8;
  localparam int ALG_BITS  = 64;
  localparam int NUM_W     = 31;
  localparam int TEXT_W    = 16;
  localparam int OUT_DATA_W = 184;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] KEY_A = 8'h41;
  localparam logic [7:0] KEY_B = 8'h42;
  localparam logic [7:0] KEY_F = 8'h46;
  localparam logic [7:0] KEY_M = 8'h4d;
  localparam logic [7:0] KEY_T = 8'h54;
  localparam logic [7:0] KEY_W = 8'h57;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_STEREO = 2'd1;
  localparam logic [1:0] MODE_DUAL   = 2'd2;
  localparam logic [1:0] MODE_MONO   = 2'd3;

  localparam int NUM_KW = 3;

  // keyword text, first character in the low byte
  localparam logic [127:0] KW_TEXT [NUM_KW] = '{
    128'h6f_65_72_65_74_73,
    128'h6f_6e_6f_6d_2d_6c_61_75_64,
    128'h6f_6e_6f_6d
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd9, 4'd4};
  localparam logic [1:0] KW_CODE [NUM_KW] = '{MODE_STEREO, MODE_DUAL, MODE_MONO};

  typedef struct packed {
    logic [ALG_BITS-1:0] algorithm_chars;
    logic [3:0]          algorithm_length;
    logic [NUM_W-1:0]    sample_rate;
    logic [NUM_W-1:0]    bit_rate;
    logic [NUM_W-1:0]    word_length;
    logic [1:0]          mode;
    logic [1:0]          channels;
    logic [TEXT_W-1:0]   text_length;
    logic                last_record;
  } chl_record_t;

  typedef struct packed {
    logic        emit;
    chl_record_t rec;
  } chl_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/chl_parse.sv
// per-line parse state and the next-state logic for one history byte
// depends on chl_pkg
`default_nettype none

module chl_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_chunk,
  output chl_pkg::chl_result_t   result
);

  typedef enum logic [2:0] {
    ST_START,
    ST_KEY,
    ST_VALUE,
    ST_DIGITS,
    ST_SKIP
  } field_state_t;

  field_state_t                   field_state_r, field_state_nxt;
  logic [7:0]                     pending_key_r, pending_key_nxt;
  logic [chl_pkg::ALG_BITS-1:0]   alg_buffer_r, alg_buffer_nxt;
  logic [3:0]                     alg_count_r, alg_count_nxt;
  logic [chl_pkg::NUM_W-1:0]      freq_acc_r, freq_acc_nxt;
  logic [chl_pkg::NUM_W-1:0]      brate_acc_r, brate_acc_nxt;
  logic [chl_pkg::NUM_W-1:0]      wlen_acc_r, wlen_acc_nxt;
  logic [7:0]                     mode_match_r, mode_match_nxt;
  logic [1:0]                     line_mode_r, line_mode_nxt;
  logic [chl_pkg::TEXT_W-1:0]     text_count_r, text_count_nxt;
  logic                           line_open_r, line_open_nxt;
  logic                           history_done_r, history_done_nxt;

  logic                           is_digit;
  logic [chl_pkg::NUM_W-1:0]      acc_sel;
  logic [chl_pkg::NUM_W+3:0]      acc_prod;
  logic [chl_pkg::NUM_W-1:0]      acc_digit;

  assign is_digit = (in_byte >= chl_pkg::CH_ZERO) && (in_byte <= chl_pkg::CH_NINE);

  // one shared decimal step for whichever numeric key is open
  always_comb begin
    case (pending_key_r)
      chl_pkg::KEY_F: acc_sel = freq_acc_r;
      chl_pkg::KEY_B: acc_sel = brate_acc_r;
      default:        acc_sel = wlen_acc_r;
    endcase
    acc_prod = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
             + {31'b0, in_byte[3:0]};
    if (acc_prod > {4'b0, {chl_pkg::NUM_W{1'b1}}}) begin
      acc_digit = {chl_pkg::NUM_W{1'b1}};
    end else begin
      acc_digit = acc_prod[chl_pkg::NUM_W-1:0];
    end
  end

  always_comb begin
    logic [2:0] alive;
    logic [3:0] pos;
    logic [2:0] new_alive;
    logic       line_end;
    logic       hist_end;
    logic       num_write;
    logic       num_clear;

    field_state_nxt  = field_state_r;
    pending_key_nxt  = pending_key_r;
    alg_buffer_nxt   = alg_buffer_r;
    alg_count_nxt    = alg_count_r;
    freq_acc_nxt     = freq_acc_r;
    brate_acc_nxt    = brate_acc_r;
    wlen_acc_nxt     = wlen_acc_r;
    mode_match_nxt   = mode_match_r;
    line_mode_nxt    = line_mode_r;
    text_count_nxt   = text_count_r;
    line_open_nxt    = line_open_r;
    history_done_nxt = history_done_r;
    result           = '0;
    alive            = mode_match_r[6:4];
    pos              = mode_match_r[3:0];
    new_alive        = '0;
    line_end         = 1'b0;
    hist_end         = 1'b0;
    num_write        = 1'b0;
    num_clear        = 1'b0;

    if (history_done_r) begin
      if (end_of_chunk) begin
        history_done_nxt = 1'b0;
      end
    end else begin
      if (in_byte >= chl_pkg::CH_SPACE) begin
        line_open_nxt = 1'b1;
        hist_end      = end_of_chunk;
        case (field_state_r)
          ST_START: begin
            if (in_byte != chl_pkg::CH_COMMA) begin
              if (in_byte == chl_pkg::KEY_A || in_byte == chl_pkg::KEY_F ||
                  in_byte == chl_pkg::KEY_B || in_byte == chl_pkg::KEY_W ||
                  in_byte == chl_pkg::KEY_M || in_byte == chl_pkg::KEY_T) begin
                pending_key_nxt = in_byte;
                field_state_nxt = ST_KEY;
              end else begin
                field_state_nxt = ST_SKIP;
              end
            end
          end
          ST_KEY: begin
            if (in_byte == chl_pkg::CH_EQUAL) begin
              field_state_nxt = ST_VALUE;
              case (pending_key_r)
                chl_pkg::KEY_A: begin
                  alg_buffer_nxt = '0;
                  alg_count_nxt  = '0;
                end
                chl_pkg::KEY_M: mode_match_nxt = 8'h70;
                chl_pkg::KEY_T: text_count_nxt = '0;
                default:        num_clear = 1'b1;
              endcase
            end else if (in_byte == chl_pkg::CH_COMMA) begin
              field_state_nxt = ST_START;
            end else begin
              field_state_nxt = ST_SKIP;
            end
          end
          ST_VALUE: begin
            if (in_byte == chl_pkg::CH_COMMA) begin
              // closing an M= field commits a fully matched keyword
              if (pending_key_r == chl_pkg::KEY_M) begin
                for (int k = 0; k < chl_pkg::NUM_KW; k++) begin
                  if (alive[k] && pos == chl_pkg::KW_LEN[k]) begin
                    line_mode_nxt = chl_pkg::KW_CODE[k];
                  end
                end
              end
              field_state_nxt = ST_START;
            end else begin
              case (pending_key_r)
                chl_pkg::KEY_A: begin
                  if (alg_count_r < 4'(chl_pkg::ALG_CHARS)) begin
                    alg_buffer_nxt[{alg_count_r[2:0], 3'b000} +: 8] = in_byte;
                    alg_count_nxt = alg_count_r + 4'd1;
                  end
                end
                chl_pkg::KEY_M: begin
                  for (int k = 0; k < chl_pkg::NUM_KW; k++) begin
                    new_alive[k] = alive[k] && (pos < chl_pkg::KW_LEN[k]) &&
                                   (chl_pkg::KW_TEXT[k][{pos, 3'b000} +: 8] == in_byte);
                  end
                  mode_match_nxt = {1'b0, new_alive,
                                    (pos != 4'hf) ? pos + 4'd1 : pos};
                end
                chl_pkg::KEY_T: begin
                  if (text_count_r != {chl_pkg::TEXT_W{1'b1}}) begin
                    text_count_nxt = text_count_r + 16'd1;
                  end
                end
                chl_pkg::KEY_F, chl_pkg::KEY_B, chl_pkg::KEY_W: begin
                  if (in_byte == chl_pkg::CH_PLUS) begin
                    field_state_nxt = ST_DIGITS;
                  end else if (is_digit) begin
                    num_write       = 1'b1;
                    field_state_nxt = ST_DIGITS;
                  end else if (in_byte != chl_pkg::CH_SPACE) begin
                    field_state_nxt = ST_SKIP;
                  end
                end
                default: field_state_nxt = ST_SKIP;
              endcase
            end
          end
          ST_DIGITS: begin
            if (in_byte == chl_pkg::CH_COMMA) begin
              field_state_nxt = ST_START;
            end else if (is_digit) begin
              num_write = 1'b1;
            end else begin
              field_state_nxt = ST_SKIP;
            end
          end
          default: begin
            if (in_byte == chl_pkg::CH_COMMA) begin
              field_state_nxt = ST_START;
            end
          end
        endcase

        if (num_clear || num_write) begin
          case (pending_key_r)
            chl_pkg::KEY_F: freq_acc_nxt  = num_clear ? '0 : acc_digit;
            chl_pkg::KEY_B: brate_acc_nxt = num_clear ? '0 : acc_digit;
            default:        wlen_acc_nxt  = num_clear ? '0 : acc_digit;
          endcase
        end
      end else begin
        line_end = 1'b1;
        hist_end = (in_byte == chl_pkg::CH_NUL) || end_of_chunk;
      end

      if (line_end || hist_end) begin
        // the line close also closes the open field
        if (field_state_nxt == ST_VALUE && pending_key_nxt == chl_pkg::KEY_M) begin
          for (int k = 0; k < chl_pkg::NUM_KW; k++) begin
            if (mode_match_nxt[4+k] && mode_match_nxt[3:0] == chl_pkg::KW_LEN[k]) begin
              line_mode_nxt = chl_pkg::KW_CODE[k];
            end
          end
        end
        result.emit                 = line_open_nxt || hist_end;
        result.rec.algorithm_chars  = alg_buffer_nxt;
        result.rec.algorithm_length = alg_count_nxt;
        result.rec.sample_rate      = freq_acc_nxt;
        result.rec.bit_rate         = brate_acc_nxt;
        result.rec.word_length      = wlen_acc_nxt;
        result.rec.mode             = line_mode_nxt;
        case (line_mode_nxt)
          chl_pkg::MODE_MONO:                     result.rec.channels = 2'd1;
          chl_pkg::MODE_STEREO, chl_pkg::MODE_DUAL: result.rec.channels = 2'd2;
          default:                                result.rec.channels = 2'd0;
        endcase
        result.rec.text_length = text_count_nxt;
        result.rec.last_record = hist_end;
        history_done_nxt       = hist_end && !end_of_chunk;
      end
    end

    if (!step) begin
      result.emit = 1'b0;
    end
  end

  logic clear_all;
  assign clear_all = result.emit || (history_done_r && end_of_chunk);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_state_r  <= ST_START;
      pending_key_r  <= '0;
      alg_buffer_r   <= '0;
      alg_count_r    <= '0;
      freq_acc_r     <= '0;
      brate_acc_r    <= '0;
      wlen_acc_r     <= '0;
      mode_match_r   <= '0;
      line_mode_r    <= '0;
      text_count_r   <= '0;
      line_open_r    <= 1'b0;
      history_done_r <= 1'b0;
    end else if (step) begin
      history_done_r <= history_done_nxt;
      if (clear_all || (!history_done_r && in_byte < chl_pkg::CH_SPACE)) begin
        field_state_r <= ST_START;
        pending_key_r <= '0;
        alg_buffer_r  <= '0;
        alg_count_r   <= '0;
        freq_acc_r    <= '0;
        brate_acc_r   <= '0;
        wlen_acc_r    <= '0;
        mode_match_r  <= '0;
        line_mode_r   <= '0;
        text_count_r  <= '0;
        line_open_r   <= 1'b0;
      end else begin
        field_state_r <= field_state_nxt;
        pending_key_r <= pending_key_nxt;
        alg_buffer_r  <= alg_buffer_nxt;
        alg_count_r   <= alg_count_nxt;
        freq_acc_r    <= freq_acc_nxt;
        brate_acc_r   <= brate_acc_nxt;
        wlen_acc_r    <= wlen_acc_nxt;
        mode_match_r  <= mode_match_nxt;
        line_mode_r   <= line_mode_nxt;
        text_count_r  <= text_count_nxt;
        line_open_r   <= line_open_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/coding_history_line_parser.sv
// coding history line parser top level: input register, parse core, result register
// depends on chl_pkg, chl_parse and assert_macros.svh
//
//   channel | direction | tdata                         | tlast
//   in_     | slave     | in_byte                       | end_of_chunk
//   out_    | master    | algorithm_chars .. text_length | last_record
//
// one byte per cycle while not stalled; out_tvalid is set from the result register
// the parse state and the digit step (x10 add with saturation) sit between the
// input register and the result register
// synchronous active-low reset empties both registers and clears the line state
// a held result stalls the input register, and in_tready drops only when both are full
// and out_tready is low
`default_nettype none
`include "assert_macros.svh"

module coding_history_line_parser (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [7:0]                        in_tdata,   // in_byte
  input  wire logic                              in_tlast,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // algorithm_chars, algorithm_length, sample_rate, bit_rate, word_length, mode,
  // channels, text_length, zero pad
  output      logic [chl_pkg::OUT_DATA_W-1:0]    out_tdata,
  output      logic                              out_tlast
);

  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic                  in_eoc_r;
  logic                  out_valid_r;
  chl_pkg::chl_record_t  record_r;
  chl_pkg::chl_result_t  result;
  logic                  advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  chl_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .in_byte      (in_byte_r),
    .end_of_chunk (in_eoc_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eoc_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      record_r <= result.rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = record_r.last_record;
  assign out_tdata  = {3'b000,
                       record_r.text_length,
                       record_r.channels,
                       record_r.mode,
                       record_r.word_length,
                       record_r.bit_rate,
                       record_r.sample_rate,
                       record_r.algorithm_length,
                       record_r.algorithm_chars};

  `ASSERT_CLK(a_channels_follow_mode, out_valid_r |-> ((record_r.mode == chl_pkg::MODE_MONO && record_r.channels == 2'd1) || (record_r.mode == chl_pkg::MODE_NONE && record_r.channels == 2'd0) || (record_r.mode != chl_pkg::MODE_MONO && record_r.mode != chl_pkg::MODE_NONE && record_r.channels == 2'd2)), "channel count does not match mode")
  `ASSERT_CLK(a_alg_length_bound, out_valid_r |-> (record_r.algorithm_length <= 4'(chl_pkg::ALG_CHARS)), "algorithm length beyond limit")
  `ASSERT_ALWAYS(a_ready_when_output_free, (in_valid_r && !out_valid_r) |-> in_tready, "input stalled with free output")
  `ASSERT_CLK(a_result_held_on_stall, (out_valid_r && !out_tready) |=> (out_valid_r && $stable(record_r)), "result changed while stalled")

endmodule

`default_nettype wire
